// File: rtl/core/sncr_pkg.sv
// ----------------------------------------------------------------------------
// sncr_pkg
// Shared types and codes for the sorted node child router.
// ----------------------------------------------------------------------------
package sncr_pkg;

  localparam int CHILD_W = 31;
  localparam int POS_W   = 8;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_LOOKUP     = 3'd0,
    OP_FIND_CHILD = 3'd1,
    OP_READ_ENTRY = 3'd2,
    OP_INSERT     = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_NEW_ROOT   = 3'd5,
    OP_TAKE_ONLY  = 3'd6,
    OP_BAD        = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_WAIT,
    S_FIND_RD,
    S_FIND_WAIT,
    S_ENT_RD,
    S_ENT_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_ROOT1,
    S_ROOT0,
    S_DONE
  } state_t;

endpackage

// File: rtl/core/sncr_mem.sv
// ----------------------------------------------------------------------------
// sncr_mem
// Entry store: key and child per entry, one write and one read port,
// separate key and child write enables, registered read data.
// ----------------------------------------------------------------------------
module sncr_mem #(
  parameter int DEPTH = 256,
  parameter int KW    = 32,
  parameter int AW    = 8
) (
  input  logic                         clk,
  input  logic                         kwe,
  input  logic                         cwe,
  input  logic [AW-1:0]                waddr,
  input  logic [KW-1:0]                wkey,
  input  logic [sncr_pkg::CHILD_W-1:0] wchild,
  input  logic [AW-1:0]                raddr,
  output logic [KW-1:0]                rkey,
  output logic [sncr_pkg::CHILD_W-1:0] rchild
);
  logic [KW-1:0]                keys [DEPTH];
  logic [sncr_pkg::CHILD_W-1:0] kids [DEPTH];

  always_ff @(posedge clk) begin
    if (kwe) begin
      keys[waddr] <= wkey;
    end
    if (cwe) begin
      kids[waddr] <= wchild;
    end
    rkey   <= keys[raddr];
    rchild <= kids[raddr];
  end
endmodule

// File: rtl/core/sorted_node_child_router_core.sv
// ----------------------------------------------------------------------------
// sorted_node_child_router_core
// One B+ tree internal node held in a key/child entry memory.
// A rejected request goes straight to the result; lookup runs a binary
// search over the keys, find_child and insert scan the entries, and
// insert and remove shift the entries that follow the position.
// One request in flight; the next is taken only after the result is accepted.
// Reset: rst (synchronous) clears the count and control; memory is unset.
// ----------------------------------------------------------------------------
module sorted_node_child_router_core #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // func[2:0], search_key[34:3], child_id[65:35], anchor_child[96:66],
  // position[104:97], zero fill
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // routed_child[30:0], entry_key[62:31], found_position[70:63],
  // entry_count[79:71], status[81:80], zero fill
  output logic [87:0]  m_tdata
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int CH = sncr_pkg::CHILD_W;

  sncr_pkg::state_t  state, state_next;
  sncr_pkg::op_t     op, in_op;
  sncr_pkg::status_t r_stat;

  logic [31:0]          skey;
  logic [CH-1:0]        cid, anchor;
  logic [7:0]           pos;
  logic [CW-1:0]        count;
  logic [CW-1:0]        lo, hi, mid;
  logic [CW-1:0]        idx, at;

  logic [CH-1:0]        r_child;
  logic [31:0]          r_key;
  logic [7:0]           r_pos;

  logic                 kwe, cwe;
  logic [AW-1:0]        waddr, raddr;
  logic [KEY_WIDTH-1:0] wkey, rkey, skey_m;
  logic [CH-1:0]        wchild, rchild;

  logic                 in_bad, pos_bad;
  logic                 lk_done, scan_end, hit, full, no_shift, shift_last;

  assign skey_m = KEY_WIDTH'(skey);

  sncr_mem #(.DEPTH(CAPACITY), .KW(KEY_WIDTH), .AW(AW)) u_mem (
    .clk(clk), .kwe(kwe), .cwe(cwe), .waddr(waddr), .wkey(wkey),
    .wchild(wchild), .raddr(raddr), .rkey(rkey), .rchild(rchild)
  );

  assign in_op      = sncr_pkg::op_t'(s_tdata[2:0]);
  assign pos_bad    = 32'(s_tdata[104:97]) >= 32'(count);
  assign mid        = lo + ((hi - lo) >> 1);
  assign lk_done    = lo > hi;
  assign scan_end   = idx >= count;
  assign hit        = rchild == ((op == sncr_pkg::OP_INSERT) ? anchor : cid);
  assign full       = count >= CW'(CAPACITY);
  assign no_shift   = idx == count - 1'b1;
  assign shift_last = idx == at;

  assign s_tready = (state == sncr_pkg::S_IDLE);
  assign m_tvalid = (state == sncr_pkg::S_DONE);
  assign m_tdata  = {6'd0, r_stat, 9'(count), r_pos, r_key, r_child};

  always_comb begin
    case (in_op)
      sncr_pkg::OP_LOOKUP, sncr_pkg::OP_TAKE_ONLY: in_bad = (count == '0);
      sncr_pkg::OP_READ_ENTRY, sncr_pkg::OP_REMOVE: in_bad = pos_bad;
      sncr_pkg::OP_FIND_CHILD, sncr_pkg::OP_INSERT, sncr_pkg::OP_NEW_ROOT: in_bad = 1'b0;
      default: in_bad = 1'b1;
    endcase
  end

  always_comb begin
    state_next = state;
    kwe = 1'b0;
    cwe = 1'b0;
    waddr = '0;
    wkey = skey_m;
    wchild = cid;
    raddr = '0;
    case (state)
      sncr_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (in_bad) begin
            state_next = sncr_pkg::S_DONE;
          end else begin
            case (in_op)
              sncr_pkg::OP_LOOKUP: state_next = sncr_pkg::S_LK_RD;
              sncr_pkg::OP_READ_ENTRY, sncr_pkg::OP_TAKE_ONLY: state_next = sncr_pkg::S_ENT_RD;
              sncr_pkg::OP_REMOVE: state_next = sncr_pkg::S_SHIFT_RD;
              sncr_pkg::OP_NEW_ROOT: state_next = sncr_pkg::S_ROOT1;
              default: state_next = sncr_pkg::S_FIND_RD;
            endcase
          end
        end
      end
      sncr_pkg::S_LK_RD: begin
        raddr = lk_done ? AW'(hi) : AW'(mid);
        state_next = sncr_pkg::S_LK_WAIT;
      end
      sncr_pkg::S_LK_WAIT: begin
        state_next = lk_done ? sncr_pkg::S_DONE : sncr_pkg::S_LK_RD;
      end
      sncr_pkg::S_FIND_RD: begin
        raddr = AW'(idx);
        state_next = scan_end ? sncr_pkg::S_DONE : sncr_pkg::S_FIND_WAIT;
      end
      sncr_pkg::S_FIND_WAIT: begin
        if (!hit) state_next = sncr_pkg::S_FIND_RD;
        else if (op == sncr_pkg::OP_FIND_CHILD || full) state_next = sncr_pkg::S_DONE;
        else if (no_shift) state_next = sncr_pkg::S_PUT;
        else state_next = sncr_pkg::S_SHIFT_RD;
      end
      sncr_pkg::S_SHIFT_RD: begin
        raddr = AW'(idx);
        if (op == sncr_pkg::OP_REMOVE && scan_end) state_next = sncr_pkg::S_DONE;
        else state_next = sncr_pkg::S_SHIFT_WR;
      end
      sncr_pkg::S_SHIFT_WR: begin
        kwe = 1'b1;
        cwe = 1'b1;
        wkey = rkey;
        wchild = rchild;
        if (op == sncr_pkg::OP_INSERT) begin
          waddr = AW'(idx + 1'b1);
          state_next = shift_last ? sncr_pkg::S_PUT : sncr_pkg::S_SHIFT_RD;
        end else begin
          waddr = AW'(idx - 1'b1);
          state_next = sncr_pkg::S_SHIFT_RD;
        end
      end
      sncr_pkg::S_PUT: begin
        kwe = 1'b1;
        cwe = 1'b1;
        waddr = AW'(at);
        state_next = sncr_pkg::S_DONE;
      end
      sncr_pkg::S_ROOT1: begin
        kwe = 1'b1;
        cwe = 1'b1;
        waddr = AW'(1);
        state_next = sncr_pkg::S_ROOT0;
      end
      sncr_pkg::S_ROOT0: begin
        // child 0 only; key 0 keeps its contents
        cwe = 1'b1;
        waddr = '0;
        wchild = anchor;
        state_next = sncr_pkg::S_DONE;
      end
      sncr_pkg::S_ENT_RD: begin
        raddr = (op == sncr_pkg::OP_READ_ENTRY) ? AW'(pos) : '0;
        state_next = sncr_pkg::S_ENT_WAIT;
      end
      sncr_pkg::S_ENT_WAIT: state_next = sncr_pkg::S_DONE;
      sncr_pkg::S_DONE: begin
        if (m_tready) state_next = sncr_pkg::S_IDLE;
      end
      default: state_next = sncr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sncr_pkg::S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        sncr_pkg::S_IDLE: begin
          if (s_tvalid) begin
            op      <= in_op;
            skey    <= s_tdata[34:3];
            cid     <= s_tdata[65:35];
            anchor  <= s_tdata[96:66];
            pos     <= s_tdata[104:97];
            r_child <= '0;
            r_key   <= '0;
            r_pos   <= '0;
            r_stat  <= in_bad ? sncr_pkg::ST_BAD : sncr_pkg::ST_OK;
            lo      <= CW'(1);
            hi      <= count - 1'b1;
            idx     <= (in_op == sncr_pkg::OP_REMOVE) ? CW'(s_tdata[104:97]) + 1'b1 : '0;
          end
        end
        sncr_pkg::S_LK_WAIT: begin
          if (lk_done) begin
            r_child <= rchild;
            r_pos <= 8'(hi);
          end else if (skey_m < rkey) begin
            hi <= mid - 1'b1;
          end else begin
            lo <= mid + 1'b1;
          end
        end
        sncr_pkg::S_FIND_RD: begin
          if (scan_end) r_stat <= sncr_pkg::ST_NOT_FOUND;
        end
        sncr_pkg::S_FIND_WAIT: begin
          if (!hit) begin
            idx <= idx + 1'b1;
          end else if (op == sncr_pkg::OP_FIND_CHILD) begin
            r_pos <= 8'(idx);
          end else if (full) begin
            r_stat <= sncr_pkg::ST_FULL;
          end else begin
            at <= idx + 1'b1;
            idx <= count - 1'b1;
          end
        end
        sncr_pkg::S_SHIFT_RD: begin
          if (op == sncr_pkg::OP_REMOVE && scan_end) count <= count - 1'b1;
        end
        sncr_pkg::S_SHIFT_WR: begin
          idx <= (op == sncr_pkg::OP_INSERT) ? idx - 1'b1 : idx + 1'b1;
        end
        sncr_pkg::S_PUT: begin
          count <= count + 1'b1;
          r_pos <= 8'(at);
        end
        sncr_pkg::S_ROOT0: begin
          count <= CW'(2);
          r_pos <= 8'd1;
        end
        sncr_pkg::S_ENT_WAIT: begin
          r_child <= rchild;
          if (op == sncr_pkg::OP_READ_ENTRY) begin
            r_key <= 32'(rkey);
            r_pos <= pos;
          end else begin
            count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: dv/tb_sorted_node_child_router_core.sv
// ----------------------------------------------------------------------------
// tb_sorted_node_child_router_core
// Self-checking bench for the B+ tree internal node router.
// Directed table (empty node, extremes, error codes), a fill-to-capacity
// pass, then random well-formed node edits mixed with noise. Every result
// is checked field by field against a typed expected result or an in-bench node model.
// ----------------------------------------------------------------------------
module tb_sorted_node_child_router_core;

  localparam int  NODE_CAP    = 256;
  localparam int  RAND_REQS   = 320;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [30:0]       child;
    logic [31:0]       key;
    logic [7:0]        pos;
    logic [8:0]        count;
    sncr_pkg::status_t status;
  } node_result_t;

  typedef struct {
    sncr_pkg::op_t op;
    logic [31:0]   key;
    logic [30:0]   cid;
    logic [30:0]   anchor;
    logic [7:0]    pos;
    bit            typed;
    node_result_t  res;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [87:0]  m_tdata;

  // node model
  logic [31:0]  node_key [NODE_CAP];
  logic [30:0]  node_child [NODE_CAP];
  bit           key_written [NODE_CAP];
  int           node_cnt = 0;

  node_result_t result_q [$];
  dir_row_t     dir_tbl [$];
  int           errors = 0;
  int           cycles = 0;
  int           n_sent = 0;
  bit           idle_en = 1'b0;
  bit           stalled_once = 1'b0;
  int           hold = 0;

  sorted_node_child_router_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int find_child_idx(logic [30:0] c);
    for (int i = 0; i < node_cnt; i++)
      if (node_child[i] == c) return i;
    return -1;
  endfunction

  function automatic node_result_t apply_node_op(sncr_pkg::op_t op, logic [31:0] k,
                                                 logic [30:0] c, logic [30:0] a,
                                                 logic [7:0] p);
    node_result_t r;
    int lo, hi, mid, idx, at;
    r = '0;
    r.status = sncr_pkg::ST_OK;
    case (op)
      sncr_pkg::OP_LOOKUP: begin
        if (node_cnt == 0) begin
          r.status = sncr_pkg::ST_BAD;
        end else begin
          lo = 1;
          hi = node_cnt - 1;
          while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (k < node_key[mid]) hi = mid - 1;
            else lo = mid + 1;
          end
          r.child = node_child[hi];
          r.pos = hi[7:0];
        end
      end
      sncr_pkg::OP_FIND_CHILD: begin
        idx = find_child_idx(c);
        if (idx < 0) r.status = sncr_pkg::ST_NOT_FOUND;
        else r.pos = idx[7:0];
      end
      sncr_pkg::OP_READ_ENTRY: begin
        if (p >= node_cnt) begin
          r.status = sncr_pkg::ST_BAD;
        end else begin
          r.child = node_child[p];
          r.key = node_key[p];
          r.pos = p;
        end
      end
      sncr_pkg::OP_INSERT: begin
        idx = find_child_idx(a);
        if (idx < 0) begin
          r.status = sncr_pkg::ST_NOT_FOUND;
        end else if (node_cnt >= NODE_CAP) begin
          r.status = sncr_pkg::ST_FULL;
        end else begin
          at = idx + 1;
          for (int i = node_cnt; i > at; i--) begin
            node_key[i] = node_key[i-1];
            node_child[i] = node_child[i-1];
            key_written[i] = key_written[i-1];
          end
          node_key[at] = k;
          node_child[at] = c;
          key_written[at] = 1'b1;
          node_cnt++;
          r.pos = at[7:0];
        end
      end
      sncr_pkg::OP_REMOVE: begin
        if (p >= node_cnt) begin
          r.status = sncr_pkg::ST_BAD;
        end else begin
          for (int i = p; i + 1 < node_cnt; i++) begin
            node_key[i] = node_key[i+1];
            node_child[i] = node_child[i+1];
            key_written[i] = key_written[i+1];
          end
          node_cnt--;
        end
      end
      sncr_pkg::OP_NEW_ROOT: begin
        node_key[1] = k;
        key_written[1] = 1'b1;
        node_child[0] = a;
        node_child[1] = c;
        node_cnt = 2;
        r.pos = 8'd1;
      end
      sncr_pkg::OP_TAKE_ONLY: begin
        if (node_cnt == 0) begin
          r.status = sncr_pkg::ST_BAD;
        end else begin
          r.child = node_child[0];
          node_cnt = 0;
        end
      end
      default: r.status = sncr_pkg::ST_BAD;
    endcase
    r.count = node_cnt[8:0];
    return r;
  endfunction

  task automatic send_req(sncr_pkg::op_t op, logic [31:0] k, logic [30:0] c,
                          logic [30:0] a, logic [7:0] p, bit typed,
                          node_result_t typed_res);
    node_result_t r;
    if (idle_en && $urandom_range(99) < 11) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tdata = {7'b0, p, a, c, k, op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    r = apply_node_op(op, k, c, a, p);
    result_q.push_back(typed ? typed_res : r);
    n_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic add_row(sncr_pkg::op_t op, logic [31:0] k, logic [30:0] c,
                         logic [30:0] a, logic [7:0] p, bit typed, node_result_t r);
    dir_row_t row;
    row.op = op; row.key = k; row.cid = c; row.anchor = a; row.pos = p;
    row.typed = typed; row.res = r;
    dir_tbl.push_back(row);
  endtask

  function automatic node_result_t mk(logic [30:0] c, logic [31:0] k, logic [7:0] p,
                                      logic [8:0] n, sncr_pkg::status_t s);
    node_result_t r;
    r.child = c; r.key = k; r.pos = p; r.count = n; r.status = s;
    return r;
  endfunction

  // random request shaped by the current node contents
  task automatic send_random();
    sncr_pkg::op_t op;
    logic [31:0]   k, lo_k, hi_k;
    logic [30:0]   c, a;
    logic [7:0]    p;
    int            w, idx;
    k = $urandom;
    c = 31'($urandom);
    a = 31'($urandom);
    p = 8'($urandom);
    w = $urandom_range(99);
    if (node_cnt == 0)
      op = (w < 70) ? sncr_pkg::OP_NEW_ROOT : sncr_pkg::op_t'($urandom_range(7));
    else if (w < 25) op = sncr_pkg::OP_LOOKUP;
    else if (w < 35) op = sncr_pkg::OP_FIND_CHILD;
    else if (w < 45) op = sncr_pkg::OP_READ_ENTRY;
    else if (w < 70) op = (node_cnt > 40) ? sncr_pkg::OP_REMOVE : sncr_pkg::OP_INSERT;
    else if (w < 84) op = sncr_pkg::OP_REMOVE;
    else if (w < 88) op = sncr_pkg::OP_NEW_ROOT;
    else if (w < 91) op = sncr_pkg::OP_TAKE_ONLY;
    else op = sncr_pkg::op_t'($urandom_range(7));
    if (node_cnt > 0 && $urandom_range(99) < 80) begin
      idx = $urandom_range(node_cnt - 1);
      case (op)
        sncr_pkg::OP_FIND_CHILD: c = node_child[idx];
        sncr_pkg::OP_READ_ENTRY, sncr_pkg::OP_REMOVE: p = idx[7:0];
        sncr_pkg::OP_INSERT: begin
          a = node_child[idx];
          lo_k = (idx == 0) ? 32'd0 : node_key[idx];
          hi_k = (idx + 1 < node_cnt) ? node_key[idx+1] : 32'hFFFF_FFFF;
          if (hi_k > lo_k) k = $urandom_range(hi_k, lo_k);
        end
        sncr_pkg::OP_LOOKUP: if ($urandom_range(1)) k = node_key[idx];
        default: ;
      endcase
    end
    if (op == sncr_pkg::OP_READ_ENTRY && p < node_cnt && !key_written[p])
      op = sncr_pkg::OP_LOOKUP;
    send_req(op, k, c, a, p, 1'b0, '0);
  endtask

  // receiver: random ready, one long hold-off to back up the input side
  always @(negedge clk) begin
    if (!stalled_once && n_sent >= 120) begin
      stalled_once <= 1'b1;
      hold <= 300;
      m_tready <= 1'b0;
    end else if (hold > 0) begin
      hold <= hold - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_en && $urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin
    node_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[30:0], m_tdata[62:31], m_tdata[70:63], m_tdata[79:71],
             sncr_pkg::status_t'(m_tdata[81:80])};
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp child=%h key=%h pos=%0d cnt=%0d st=%0d / %s",
                     want.child, want.key, want.pos, want.count, want.status,
                     $sformatf("got child=%h key=%h pos=%0d cnt=%0d st=%0d",
                               got.child, got.key, got.pos, got.count, got.status));
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NODE_CAP; i++) key_written[i] = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // empty node, error codes, extremes
    add_row(sncr_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 8'd0, 1,
            mk('0, '0, 8'd0, 9'd0, sncr_pkg::ST_BAD));
    add_row(sncr_pkg::OP_TAKE_ONLY, '0, '0, '0, 8'd0, 1,
            mk('0, '0, 8'd0, 9'd0, sncr_pkg::ST_BAD));
    add_row(sncr_pkg::OP_FIND_CHILD, '0, '0, '0, 8'd0, 1,
            mk('0, '0, 8'd0, 9'd0, sncr_pkg::ST_NOT_FOUND));
    add_row(sncr_pkg::OP_INSERT, '1, '1, '0, 8'd0, 1,
            mk('0, '0, 8'd0, 9'd0, sncr_pkg::ST_NOT_FOUND));
    add_row(sncr_pkg::OP_REMOVE, '0, '0, '0, 8'd0, 1,
            mk('0, '0, 8'd0, 9'd0, sncr_pkg::ST_BAD));
    add_row(sncr_pkg::OP_READ_ENTRY, '0, '0, '0, 8'd255, 1,
            mk('0, '0, 8'd0, 9'd0, sncr_pkg::ST_BAD));
    add_row(sncr_pkg::OP_BAD, '1, '1, '1, 8'd255, 1,
            mk('0, '0, 8'd0, 9'd0, sncr_pkg::ST_BAD));
    add_row(sncr_pkg::OP_NEW_ROOT, 32'd100, 31'h7FFF_FFFF, 31'd0, 8'd0, 1,
            mk('0, '0, 8'd1, 9'd2, sncr_pkg::ST_OK));
    add_row(sncr_pkg::OP_INSERT, 32'hFFFF_FFFF, 31'd5, 31'h7FFF_FFFF, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_INSERT, 32'd50, 31'd3, 31'd0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_LOOKUP, 32'd0, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_LOOKUP, 32'd49, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_LOOKUP, 32'd50, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_LOOKUP, 32'd100, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_FIND_CHILD, '0, 31'd5, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_FIND_CHILD, '0, 31'd1234, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_READ_ENTRY, '0, '0, '0, 8'd3, 0, '0);
    add_row(sncr_pkg::OP_READ_ENTRY, '0, '0, '0, 8'd4, 0, '0);
    add_row(sncr_pkg::OP_REMOVE, '0, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_READ_ENTRY, '0, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_INSERT, 32'd7, 31'd8, 31'd4321, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_REMOVE, '0, '0, '0, 8'd255, 0, '0);
    add_row(sncr_pkg::OP_TAKE_ONLY, '0, '0, '0, 8'd0, 0, '0);
    add_row(sncr_pkg::OP_NEW_ROOT, 32'd0, 31'd1, 31'd2, 8'd0, 0, '0);
    foreach (dir_tbl[i])
      send_req(dir_tbl[i].op, dir_tbl[i].key, dir_tbl[i].cid, dir_tbl[i].anchor,
               dir_tbl[i].pos, dir_tbl[i].typed, dir_tbl[i].res);

    // fill to capacity by appending after the last child, then hit full
    send_req(sncr_pkg::OP_NEW_ROOT, 32'h10, 31'd1000, 31'd999, 8'd0, 0, '0);
    while (node_cnt < NODE_CAP)
      send_req(sncr_pkg::OP_INSERT, node_key[node_cnt-1] + 32'h100_0000,
               31'(1000 + node_cnt), node_child[node_cnt-1], 8'd0, 0, '0);
    send_req(sncr_pkg::OP_INSERT, 32'd1, 31'd77, 31'd999, 8'd0, 0, '0);
    send_req(sncr_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 8'd0, 0, '0);
    send_req(sncr_pkg::OP_READ_ENTRY, '0, '0, '0, 8'd255, 0, '0);
    send_req(sncr_pkg::OP_REMOVE, '0, '0, '0, 8'd255, 0, '0);
    send_req(sncr_pkg::OP_TAKE_ONLY, '0, '0, '0, 8'd0, 0, '0);

    idle_en = 1'b1;
    for (int i = 0; i < RAND_REQS; i++) begin
      idle_en = !(i >= 150 && i < 250);
      send_random();
    end

    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
